// File: src/pcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcs_pkg: shared types and constants for the percentile contrast stretch
// Register indexes, field widths and the divider request record.
// ----------------------------------------------------------------------------
package pcs_pkg;

  localparam int MAX_PIXELS_DEF = 16777216;
  localparam int VALUE_BITS_DEF = 16;
  localparam int CLIP_W         = 14;
  localparam int COUNT_W        = 25;

  // register indexes
  localparam logic [1:0] REG_LOW_CLIP  = 2'd0;
  localparam logic [1:0] REG_HIGH_CLIP = 2'd1;
  localparam logic [1:0] REG_DEPTH     = 2'd2;

  localparam logic ACT_GATHER = 1'b0;
  localparam logic ACT_MAP    = 1'b1;

  // divider request: dividend / divisor, both unsigned
  typedef struct packed {
    logic        start;
    logic [47:0] dividend;
    logic [24:0] divisor;
  } div_req_t;

endpackage

// File: src/pcs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcs_div: serial restoring divider
// One quotient bit per cycle; 48-bit dividend over a 25-bit divisor.
// ----------------------------------------------------------------------------
module pcs_div (
  input  logic             clk,
  input  logic             rst,
  input  pcs_pkg::div_req_t req,
  output logic             busy,
  output logic             done,
  output logic [47:0]      quotient
);
  import pcs_pkg::*;

  logic [47:0] quo;
  logic [25:0] rem;
  logic [24:0] dsr;
  logic [5:0]  cnt;
  logic [25:0] trial;

  assign trial    = {rem[24:0], quo[47]};
  assign quotient = quo;

  // shift-subtract iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        quo  <= req.dividend;
        rem  <= '0;
        dsr  <= req.divisor;
        cnt  <= 6'd48;
      end else if (busy) begin
        if (trial >= {1'b0, dsr}) begin
          rem <= trial - {1'b0, dsr};
          quo <= {quo[46:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[46:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("divider done without work");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    busy && !req.start |=> busy || done) else $error("divider lost");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt != 6'd0) else $error("divider count underflow");

endmodule

// File: src/percentile_contrast_stretch_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// percentile_contrast_stretch_top: two-pass percentile contrast stretch
// Histogram gather, percentile search on the last gather pixel, linear map.
// ----------------------------------------------------------------------------
// channel   direction  content
// s_axis    in         tdata {no_data,pixel_value}, tuser action, tlast is_last
// m_axis    out        tdata {written,out_value}
// apb       in         low clip, high clip, depth mode
//
// After reset a clearing pass sweeps all 2**VALUE_BITS histogram bins; no
// pixel is taken meanwhile. A valid gather pixel goes through read, update
// and write back in the single-port histogram memory before the next pixel
// is taken; a nodata one needs no memory access. Finalize runs the set-up
// states S_P1 and S_P2, one histogram walk and a clearing sweep. A map pixel
// goes to the output register directly or through the serial divider. A result
// held back by the sink stalls the input until the output register frees.
// ----------------------------------------------------------------------------
module percentile_contrast_stretch_top #(
  parameter int MAX_PIXELS = pcs_pkg::MAX_PIXELS_DEF,
  parameter int VALUE_BITS = pcs_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [15:0] pixel_value, [16] no_data
  input  logic        s_axis_tuser,  // [0] action
  input  logic        s_axis_tlast,  // is_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [15:0] out_value, [16] written
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pcs_pkg::*;

  localparam int HSIZE  = 1 << VALUE_BITS;
  localparam int PROD_W = CLIP_W + COUNT_W;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_GREAD  = 4'd2;
  localparam logic [3:0] S_GWRITE = 4'd3;
  localparam logic [3:0] S_P1     = 4'd4;
  localparam logic [3:0] S_P2     = 4'd5;
  localparam logic [3:0] S_WALK   = 4'd6;
  localparam logic [3:0] S_MDIV   = 4'd7;
  localparam logic [3:0] S_MOUT   = 4'd8;

  // times 10000 as a sum of shifts
  function automatic logic [PROD_W-1:0] times_10k(logic [COUNT_W-1:0] v);
    logic [PROD_W-1:0] w;
    w = PROD_W'(v);
    return (w << 13) + (w << 10) + (w << 9) + (w << 8) + (w << 4);
  endfunction

  // configuration
  logic [CLIP_W-1:0] low_clip, high_clip;
  logic              depth_mode;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_clip   <= '0;
      high_clip  <= '0;
      depth_mode <= 1'b1;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_LOW_CLIP:  low_clip   <= pwdata[CLIP_W-1:0];
        REG_HIGH_CLIP: high_clip  <= pwdata[CLIP_W-1:0];
        REG_DEPTH:     depth_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LOW_CLIP:  prdata = {{(32-CLIP_W){1'b0}}, low_clip};
      REG_HIGH_CLIP: prdata = {{(32-CLIP_W){1'b0}}, high_clip};
      REG_DEPTH:     prdata = {31'd0, depth_mode};
      default:       prdata = '0;
    endcase
  end

  // histogram memory
  logic [COUNT_W-1:0]    hist_mem [HSIZE];
  logic [VALUE_BITS-1:0] h_addr;
  logic                  h_we;
  logic [COUNT_W-1:0]    h_wdata, h_rdata;

  always_ff @(posedge clk) begin
    if (h_we) hist_mem[h_addr] <= h_wdata;
    h_rdata <= hist_mem[h_addr];
  end

  // datapath state
  logic [3:0]            state;
  logic [VALUE_BITS-1:0] x, sweep, rd_bin, cum_bin;
  logic                  last;
  logic [COUNT_W-1:0]    total, cum, rest;
  logic [PROD_W-1:0]     prod_lo, prod_hi, cum_scaled, rest_scaled;
  logic                  lo_hit, hi_hit;
  logic [15:0]           low_bound, high_bound;
  logic                  found_lo, found_hi, rd_valid;
  logic [15:0]           res_val;
  logic                  res_wr;
  logic                  res_pend;
  logic                  out_free;
  div_req_t              dreq;
  logic                  dbusy, ddone;
  logic [47:0]           dq;
  logic [15:0]           depth;
  logic [15:0]           px;

  assign px       = 16'(s_axis_tdata[VALUE_BITS-1:0]);
  assign depth    = depth_mode ? 16'hFFFF : 16'h00FF;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE) && !res_pend;

  // percentile tests on the running sum, without dividing by 10000
  assign rest        = total - cum;
  assign cum_scaled  = times_10k(cum);
  assign rest_scaled = times_10k(rest);
  assign lo_hit      = (cum_scaled > prod_lo) || (cum >= total);
  assign hi_hit      = (cum != '0) && (prod_hi >= rest_scaled);

  pcs_div u_div (
    .clk(clk), .rst(rst), .req(dreq), .busy(dbusy), .done(ddone), .quotient(dq)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_pend && out_free) begin
      m_axis_tvalid <= 1'b1;
      m_axis_tdata  <= {7'd0, res_wr, res_val};
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // memory port control
  always_comb begin
    h_we    = 1'b0;
    h_addr  = sweep;
    h_wdata = '0;
    dreq    = '0;
    case (state)
      S_CLEAR: h_we = 1'b1;
      S_IDLE:  h_addr = s_axis_tdata[VALUE_BITS-1:0];
      S_GREAD: h_addr = x;
      S_GWRITE: begin
        h_addr  = x;
        h_we    = 1'b1;
        h_wdata = h_rdata + COUNT_W'(1);
      end
      S_WALK: h_addr = sweep;
      default: ;
    endcase
    if (state == S_IDLE && s_axis_tvalid && s_axis_tready &&
        s_axis_tuser == ACT_MAP && high_bound > low_bound && !s_axis_tdata[16] &&
        px > low_bound && px <= high_bound) begin
      dreq.start    = 1'b1;
      dreq.dividend = {16'd0, 32'(depth) * 32'(px - low_bound)};
      dreq.divisor  = 25'(high_bound - low_bound);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      sweep      <= '0;
      total      <= '0;
      low_bound  <= '0;
      high_bound <= '0;
      res_pend   <= 1'b0;
      rd_valid   <= 1'b0;
    end else begin
      if (res_pend && out_free) res_pend <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          sweep <= sweep + VALUE_BITS'(1);
          if (sweep == VALUE_BITS'(HSIZE - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            x    <= s_axis_tdata[VALUE_BITS-1:0];
            last <= s_axis_tlast;
            if (s_axis_tuser == ACT_GATHER) begin
              if (!s_axis_tdata[16] && total < COUNT_W'(MAX_PIXELS))
                state <= S_GREAD;
              else if (s_axis_tlast)
                state <= S_P1;
            end else begin
              if (high_bound <= low_bound) begin
                res_val <= high_bound; res_wr <= 1'b1; res_pend <= 1'b1;
              end else if (s_axis_tdata[16]) begin
                res_val <= 16'd0; res_wr <= 1'b0; res_pend <= 1'b1;
              end else if (px <= low_bound) begin
                res_val <= 16'd1; res_wr <= 1'b1; res_pend <= 1'b1;
              end else if (px > high_bound) begin
                res_val <= depth; res_wr <= 1'b1; res_pend <= 1'b1;
              end else begin
                state <= S_MDIV;
              end
            end
          end
        end
        S_GREAD: state <= S_GWRITE;
        S_GWRITE: begin
          total <= total + COUNT_W'(1);
          state <= last ? S_P1 : S_IDLE;
        end
        S_P1: begin
          prod_lo <= PROD_W'(low_clip) * PROD_W'(total);
          prod_hi <= PROD_W'(high_clip) * PROD_W'(total);
          state   <= S_P2;
        end
        S_P2: begin
          sweep    <= '0;
          cum      <= '0;
          found_lo <= 1'b0;
          found_hi <= 1'b0;
          rd_valid <= 1'b0;
          if (total == '0) begin
            low_bound  <= '0;
            high_bound <= '0;
            state      <= S_CLEAR;
          end else begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          // one bin a cycle: address, read data, running sum, bound checks
          rd_valid <= 1'b1;
          rd_bin   <= sweep;
          if (rd_valid) begin
            cum     <= cum + h_rdata;
            cum_bin <= rd_bin;
          end
          if (!found_lo && lo_hit) begin
            found_lo  <= 1'b1;
            low_bound <= 16'(cum_bin);
          end
          if (!found_hi && hi_hit) begin
            found_hi   <= 1'b1;
            high_bound <= 16'(cum_bin);
          end
          if (found_lo && found_hi) begin
            state <= S_CLEAR;
            sweep <= '0;
            total <= '0;
          end else if (sweep != VALUE_BITS'(HSIZE - 1)) begin
            sweep <= sweep + VALUE_BITS'(1);
          end
        end
        S_MDIV: if (ddone) begin
          res_val  <= dq[15:0];
          res_wr   <= 1'b1;
          res_pend <= 1'b1;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_take_pending: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !res_pend) else $error("accept over pending result");
  a_clear_writes: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> h_we) else $error("clear pass without write");
  a_total_cap: assert property (@(posedge clk) disable iff (rst)
    total <= COUNT_W'(MAX_PIXELS)) else $error("valid count overflow");
  a_map_div: assert property (@(posedge clk) disable iff (rst)
    state == S_MDIV |-> dbusy || ddone) else $error("map division lost");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the percentile contrast stretch
// Images are gathered into a histogram and then mapped. A scoreboard tracks
// the histogram, the percentile bounds and the stretch, and compares each
// output transaction field by field with the oldest expected pixel. Both
// streams idle at random and a watchdog catches a hang.
// ----------------------------------------------------------------------------
module tb_top;
  import pcs_pkg::*;

  localparam int IDLE_LIMIT = 400000;
  localparam int HIST_N     = 65536;

  typedef struct packed {
    logic [15:0] value;
    logic        written;
  } pixel_out_t;

  // scoreboard: histogram, bounds and the queue of expected output pixels
  class stretch_scoreboard;
    int unsigned hist[HIST_N];
    int unsigned valid_total;
    int unsigned lo_bound, hi_bound;
    int unsigned clip_lo, clip_hi;
    bit          depth_full;
    pixel_out_t  pending_pixels[$];
    int          errors;

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_LOW_CLIP:  clip_lo = val[CLIP_W-1:0];
        REG_HIGH_CLIP: clip_hi = val[CLIP_W-1:0];
        REG_DEPTH:     depth_full = val[0];
        default: ;
      endcase
    endfunction

    // value of the sorted valid sample at position k
    function int unsigned rank_value(int unsigned k);
      longint unsigned cum;
      cum = 0;
      for (int v = 0; v < HIST_N; v++) begin
        cum += hist[v];
        if (cum > k) return v;
      end
      return 0;
    endfunction

    function void percentile_bounds();
      longint unsigned n, p1, p2;
      int unsigned ilo, ihi;
      n = valid_total;
      if (n == 0) begin
        lo_bound = 0;
        hi_bound = 0;
      end else begin
        p1 = (clip_lo * n) / 10000;
        p2 = (clip_hi * n) / 10000;
        ilo = 32'((p1 > n - 1) ? n - 1 : p1);
        ihi = 32'((p2 > n - 1) ? 0 : (n - 1) - p2);
        lo_bound = rank_value(ilo);
        hi_bound = rank_value(ihi);
      end
      foreach (hist[i]) hist[i] = 0;
      valid_total = 0;
    endfunction

    function void note_pixel(logic act, logic [15:0] px, logic nd, logic last);
      pixel_out_t e;
      longint unsigned full;
      if (act == ACT_GATHER) begin
        if (!nd && valid_total < MAX_PIXELS_DEF) begin
          hist[px]++;
          valid_total++;
        end
        if (last) percentile_bounds();
        return;
      end
      full = depth_full ? 65535 : 255;
      e.written = 1'b1;
      if (hi_bound <= lo_bound) e.value = 16'(hi_bound);
      else if (nd) begin
        e.value = 0;
        e.written = 1'b0;
      end else if (px <= lo_bound) e.value = 1;
      else if (px > hi_bound) e.value = 16'(full);
      else e.value = 16'((full * (px - lo_bound)) / (hi_bound - lo_bound));
      pending_pixels.push_back(e);
    endfunction

    function void check_result(logic [23:0] data);
      pixel_out_t e;
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected output pixel %h", $time, data);
        errors++;
        return;
      end
      e = pending_pixels.pop_front();
      if (data[15:0] !== e.value) begin
        $display("%0t: out_value expected %0d actual %0d", $time, e.value, data[15:0]);
        errors++;
      end
      if (data[16] !== e.written) begin
        $display("%0t: written expected %0b actual %0b", $time, e.written, data[16]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  stretch_scoreboard sb = new();
  bit  src_burst, snk_burst;
  int  idle_cycles;

  percentile_contrast_stretch_top uut (.*);

  always #5 clk = ~clk;

  // random gap: mostly short, now and then long, none in burst stretches
  function automatic int pick_gap(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // both streams are sampled on the falling edge ahead of the rising edge that moves them
  always @(negedge clk) begin
    if (!rst) begin
      idle_cycles <= idle_cycles + 1;
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_pixel(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[16], s_axis_tlast);
        idle_cycles <= 0;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata);
        idle_cycles <= 0;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result sink with random back-pressure
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 199) == 0) snk_burst = ~snk_burst;
      gap = pick_gap(snk_burst);
      if (gap == 0) m_axis_tready <= 1'b1;
      else begin
        m_axis_tready <= 1'b0;
        repeat (gap - 1) @(posedge clk);
      end
    end
  end

  task automatic send_pixel(logic act, logic [15:0] px, logic nd, logic last);
    int gap;
    bit ok;
    if ($urandom_range(0, 99) == 0) src_burst = ~src_burst;
    gap = pick_gap(src_burst);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {7'b0, nd, px};
    s_axis_tlast  <= last;
    do begin
      @(negedge clk);
      ok = s_axis_tready;
      @(posedge clk);
    end while (!ok);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.set_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // wait for all output pixels, then let a map division drain
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic random_image(int gathers, int lo_centre, int spread);
    logic [15:0] px;
    for (int i = 0; i < gathers; i++) begin
      if ($urandom_range(0, 9) == 0) px = 16'($urandom());
      else px = 16'(lo_centre + $urandom_range(0, spread));
      send_pixel(ACT_GATHER, px, $urandom_range(0, 9) == 0, i == gathers - 1);
    end
  endtask

  task automatic random_maps(int count);
    logic [15:0] px;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 3);
      if (r == 0) px = 16'($urandom());
      else if (r == 1) px = 16'(sb.lo_bound + $urandom_range(0, 4) - 2);
      else if (r == 2) px = 16'(sb.hi_bound + $urandom_range(0, 4) - 2);
      else px = 16'($urandom_range(sb.lo_bound, sb.hi_bound));
      send_pixel(ACT_MAP, px, $urandom_range(0, 9) == 0, 1'($urandom_range(0, 1)));
    end
  endtask

  // stimulus
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // let the clearing sweep after reset finish
    do @(negedge clk); while (!s_axis_tready);
    @(posedge clk);

    // full-range image, no clipping; last gather pixel is nodata
    apb_write(REG_LOW_CLIP, 0);
    apb_write(REG_HIGH_CLIP, 0);
    apb_write(REG_DEPTH, 1);
    send_pixel(ACT_GATHER, 16'd0, 1'b0, 1'b0);
    send_pixel(ACT_GATHER, 16'hFFFF, 1'b0, 1'b0);
    send_pixel(ACT_GATHER, 16'd1000, 1'b0, 1'b0);
    send_pixel(ACT_GATHER, 16'd500, 1'b1, 1'b1);
    send_pixel(ACT_MAP, 16'd0, 1'b0, 1'b0);
    send_pixel(ACT_MAP, 16'hFFFF, 1'b0, 1'b1);
    send_pixel(ACT_MAP, 16'd1, 1'b0, 1'b0);
    send_pixel(ACT_MAP, 16'h8000, 1'b0, 1'b0);
    send_pixel(ACT_MAP, 16'd77, 1'b1, 1'b0);
    settle();
    apb_write(REG_DEPTH, 0);
    send_pixel(ACT_MAP, 16'h8000, 1'b0, 1'b0);
    send_pixel(ACT_MAP, 16'hFFFE, 1'b0, 1'b1);
    send_pixel(ACT_MAP, 16'h5555, 1'b1, 1'b0);
    settle();

    // clip shares above 10000 clamp the indices; bounds cross
    apb_write(REG_LOW_CLIP, 32'h3FFF);
    apb_write(REG_HIGH_CLIP, 32'h3FFF);
    send_pixel(ACT_GATHER, 16'd7, 1'b0, 1'b0);
    send_pixel(ACT_GATHER, 16'd9, 1'b0, 1'b0);
    send_pixel(ACT_GATHER, 16'd300, 1'b0, 1'b1);
    send_pixel(ACT_MAP, 16'd8, 1'b0, 1'b0);
    send_pixel(ACT_MAP, 16'd8, 1'b1, 1'b0);
    // empty image: only nodata pixels
    send_pixel(ACT_GATHER, 16'd40, 1'b1, 1'b0);
    send_pixel(ACT_GATHER, 16'd41, 1'b1, 1'b1);
    send_pixel(ACT_MAP, 16'd12, 1'b0, 1'b0);
    send_pixel(ACT_MAP, 16'd12, 1'b1, 1'b0);
    settle();

    // random images with moderate clipping, depth changed between map passes
    apb_write(REG_LOW_CLIP, $urandom_range(0, 1500));
    apb_write(REG_HIGH_CLIP, $urandom_range(0, 1500));
    apb_write(REG_DEPTH, 1);
    random_image(550, $urandom_range(0, 20000), $urandom_range(100, 40000));
    random_maps(300);
    settle();
    apb_write(REG_DEPTH, 0);
    random_maps(300);
    settle();

    apb_write(REG_LOW_CLIP, $urandom_range(0, 10000));
    apb_write(REG_HIGH_CLIP, 10000);
    apb_write(REG_DEPTH, 1);
    random_image(550, $urandom_range(0, 1000), $urandom_range(10, 64000));
    random_maps(300);
    settle();
    apb_write(REG_LOW_CLIP, $urandom_range(0, 300));
    apb_write(REG_HIGH_CLIP, $urandom_range(0, 300));
    random_image(2, 0, 65535);
    random_maps(50);
    settle();

    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending_pixels.size() == 0)
      $display("Testbench completed without errors");
    else begin
      if (sb.pending_pixels.size() != 0)
        $display("%0t: %0d output pixels never arrived", $time, sb.pending_pixels.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
